// ===== rtl/core/mpbs_pkg.sv =====
// Shared types, constants and helpers for the multi-pattern byte scanner.
// No dependencies; used by mpbs_slot and multi_pattern_byte_scanner_top.
package mpbs_pkg;

	localparam int MAX_PATTERN_LEN = 8;
	localparam int PATTERN_SLOTS   = 5;
	localparam int PAT_W           = 64;
	localparam int POS_W           = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int IN_USE_W        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_E = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IN_USE    = 3'd5;

	localparam logic [IN_USE_W-1:0] IN_USE_RESET = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [PATTERN_SLOTS-1:0] found_mask;
		logic                     any_found;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic active;
	} slot_ctrl_t;

	// Length is the index of the first zero byte, capped at MAX_PATTERN_LEN.
	function automatic logic [POS_W-1:0] pattern_len(input logic [PAT_W-1:0] pat);
		logic [POS_W-1:0] len;
		logic             done;
		len  = POS_W'(MAX_PATTERN_LEN);
		done = 1'b0;
		for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
			if (!done && pat[8*i +: 8] == 8'h00) begin
				len  = POS_W'(i);
				done = 1'b1;
			end
		end
		return len;
	endfunction

endpackage

// ===== rtl/core/mpbs_slot.sv =====
// One pattern slot: match position, found flag and the per-byte update.
// Depends on mpbs_pkg.
module mpbs_slot (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpbs_pkg::slot_ctrl_t          ctrl,
	input  logic [mpbs_pkg::PAT_W-1:0]    pattern,
	input  logic [7:0]                    data_byte,
	output logic                          found,
	output logic                          found_next
);

	localparam logic [mpbs_pkg::POS_W-1:0] POS_W_ONE = 1;

	logic [mpbs_pkg::POS_W-1:0] pos_q;
	logic                       found_q;
	logic [mpbs_pkg::POS_W-1:0] len;
	logic [mpbs_pkg::POS_W-1:0] pos_c;
	logic                       found_c;
	logic [7:0]                 byte_at;
	logic [mpbs_pkg::POS_W-1:0] pos_n;

	assign len     = mpbs_pkg::pattern_len(pattern);
	assign pos_c   = ctrl.clear ? '0 : pos_q;
	assign found_c = ctrl.clear ? 1'b0 : found_q;
	assign byte_at = pattern[8*pos_c[2:0] +: 8];

	always_comb begin
		pos_n      = pos_c;
		found_next = found_c;
		if (ctrl.active && !found_c) begin
			if (pos_c < len && data_byte == byte_at) begin
				pos_n = pos_c + POS_W_ONE;
			end else if (len != '0 && data_byte == pattern[7:0]) begin
				pos_n = POS_W_ONE;
			end else if (pos_c < len || len == '0) begin
				pos_n = '0;
			end
			// a shrunk pattern leaves the position beyond its end: found below
			found_next = (pos_n >= len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (ctrl.step) begin
			pos_q   <= pos_n;
			found_q <= found_next;
		end
	end

	assign found = found_q;

endmodule

// ===== rtl/core/multi_pattern_byte_scanner_top.sv =====
// Multi-pattern byte scanner: input register, pattern slots, result register.
// Depends on mpbs_pkg and mpbs_slot.
//
// Usage:
//   Bytes enter on the item channel (valid/ready), one request per byte with
//   a first_byte mark that clears all match positions and found flags before
//   that byte is scanned. Every byte yields one result on the result channel:
//   the found mask of the five slots after that byte, and whether any is set.
//   Patterns and the slot count are written through cfg_we/cfg_index/cfg_wdata
//   while the scanner is idle; indexes beyond the register list are ignored.
// Flow and throughput:
//   A byte accepted into the input register is scanned once the result
//   register is free or being drained; its result is then registered. One
//   byte per cycle is sustained while results are taken; the slot compare
//   and position update between the input and result registers set that rate.
// Reset:
//   Positions and flags clear, patterns read as zero, five slots in use, both
//   channels empty.
// Stalls:
//   A held result keeps its value; one more byte waits in the input register,
//   after which item_ready drops until the result is taken.
module multi_pattern_byte_scanner_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  mpbs_pkg::in_item_t                item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mpbs_pkg::out_item_t               result,
	input  logic                              cfg_we,
	input  logic [mpbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpbs_pkg::PAT_W-1:0]        cfg_wdata
);

	logic [mpbs_pkg::PAT_W-1:0]        pattern_q [mpbs_pkg::PATTERN_SLOTS];
	logic [mpbs_pkg::IN_USE_W-1:0]     in_use_q;
	logic                              valid_s1;
	mpbs_pkg::in_item_t                item_s1;
	logic                              step_s1;
	logic                              result_valid_q;
	mpbs_pkg::out_item_t               result_q;
	logic [mpbs_pkg::PATTERN_SLOTS-1:0] found_cur;
	logic [mpbs_pkg::PATTERN_SLOTS-1:0] found_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mpbs_pkg::PATTERN_SLOTS; k++) begin
				pattern_q[k] <= '0;
			end
			in_use_q <= mpbs_pkg::IN_USE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				mpbs_pkg::REG_PATTERN_A, mpbs_pkg::REG_PATTERN_B, mpbs_pkg::REG_PATTERN_C,
				mpbs_pkg::REG_PATTERN_D, mpbs_pkg::REG_PATTERN_E: begin
					for (int k = 0; k < mpbs_pkg::PATTERN_SLOTS; k++) begin
						if (cfg_index == mpbs_pkg::CFG_IDX_W'(k)) begin
							pattern_q[k] <= cfg_wdata;
						end
					end
				end
				mpbs_pkg::REG_IN_USE: begin
					in_use_q <= cfg_wdata[mpbs_pkg::IN_USE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// scan the held byte when the result register is free or being drained
	assign step_s1    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (step_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	for (genvar k = 0; k < mpbs_pkg::PATTERN_SLOTS; k++) begin : g_slot
		mpbs_pkg::slot_ctrl_t ctrl;

		assign ctrl.step   = step_s1;
		assign ctrl.clear  = item_s1.first_byte;
		assign ctrl.active = (in_use_q > mpbs_pkg::IN_USE_W'(k));

		mpbs_slot u_slot (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.pattern    (pattern_q[k]),
			.data_byte  (item_s1.data_byte),
			.found      (found_cur[k]),
			.found_next (found_next[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1) begin
			result_q.found_mask <= found_next;
			result_q.any_found  <= |found_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a scanned byte always lands in the result register
	a_step_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1 |=> result_valid)
		else $error("scanned byte did not produce a result");

	// an empty input register never refuses a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but request refused");

	// flags only drop on a first-byte clear
	a_flags_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step_s1 && !item_s1.first_byte) |-> ((found_next & found_cur) == found_cur))
		else $error("found flag dropped without clear");

	// with no slot in use, a cleared stream reports nothing found
	a_clear_no_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(step_s1 && item_s1.first_byte && in_use_q == '0) |=> (result.found_mask == '0))
		else $error("found flag set with no slot in use");

endmodule
